/* rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and helpers for quaternion to Euler conversion
// Widths of the datapath, CORDIC angle table and output rounding.
// ----------------------------------------------------------------------------
package qte_pkg;

  // field and datapath widths
  localparam int IN_W  = 16;          // Q1.14 quaternion component
  localparam int PRD_W = 2 * IN_W;    // component product
  localparam int ARG_W = 34;          // atan2 argument (Q2.28 times two)
  localparam int CW    = ARG_W + 4;   // CORDIC x/y with gain headroom
  localparam int ANG_W = 26;          // angle, degrees * 65536
  localparam int OUT_W = 16;
  localparam int YAW_W = 15;

  // asin path
  localparam int SC_W    = 30;        // clamped sine, +-2^28
  localparam int REM_W   = 57;        // 1 - s^2 in Q56
  localparam int ISQ_W   = 58;
  localparam int ISQ_N   = 29;        // result bits of the square root
  localparam int ISQ_TOP = 56;        // top even bit position

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_TABLE_LEN    = 24;

  localparam logic signed [ARG_W-1:0] ONE_Q28   = ARG_W'(64'sd1 << 28);
  localparam logic signed [ANG_W-1:0] DEG90_Q16 = ANG_W'(90 * 65536);

  localparam logic signed [OUT_W-1:0] PITCH_LIM = OUT_W'(23040);
  localparam logic signed [OUT_W-1:0] YAW_LIM   = OUT_W'(11520);

  // atan(2^-i) in degrees * 65536
  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] t;
    case (i)
      0:  t = ANG_W'(2949120);
      1:  t = ANG_W'(1740967);
      2:  t = ANG_W'(919879);
      3:  t = ANG_W'(466945);
      4:  t = ANG_W'(234379);
      5:  t = ANG_W'(117304);
      6:  t = ANG_W'(58666);
      7:  t = ANG_W'(29335);
      8:  t = ANG_W'(14668);
      9:  t = ANG_W'(7334);
      10: t = ANG_W'(3667);
      11: t = ANG_W'(1833);
      12: t = ANG_W'(917);
      13: t = ANG_W'(458);
      14: t = ANG_W'(229);
      15: t = ANG_W'(115);
      16: t = ANG_W'(57);
      17: t = ANG_W'(29);
      18: t = ANG_W'(14);
      19: t = ANG_W'(7);
      20: t = ANG_W'(4);
      21: t = ANG_W'(2);
      22: t = ANG_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // round to 1/128 degree (ties up) and clamp to +-lim
  function automatic logic signed [OUT_W-1:0] round_clamp(
    input logic signed [ANG_W-1:0] ang,
    input logic signed [OUT_W-1:0] lim
  );
    logic signed [ANG_W:0] t;
    logic signed [ANG_W:0] hi;
    logic signed [ANG_W:0] r;
    t  = {ang[ANG_W-1], ang} + (ANG_W+1)'(256);
    hi = {{(ANG_W+1-OUT_W){lim[OUT_W-1]}}, lim};
    t  = t >>> 9;
    if (t > hi) begin
      r = hi;
    end else if (t < -hi) begin
      r = -hi;
    end else begin
      r = t;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

/* rtl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC atan2
// One pre-rotation stage into the right half plane, then one stage per step.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic signed [ARG_W-1:0] arg_y,
  input  logic signed [ARG_W-1:0] arg_x,
  output logic signed [ANG_W-1:0] ang
);

  typedef enum logic [1:0] {SPC_NONE, SPC_POS90, SPC_NEG90, SPC_ZERO} spc_t;

  logic signed [CW-1:0]    x_r   [0:STEPS];
  logic signed [CW-1:0]    y_r   [0:STEPS];
  logic signed [ANG_W-1:0] ang_r [0:STEPS];
  spc_t                    spc_r [0:STEPS];

  logic signed [CW-1:0] xi;
  logic signed [CW-1:0] yi;
  assign xi = CW'(arg_x);
  assign yi = CW'(arg_y);

  // pre-rotation and zero-cosine cases
  always_ff @(posedge clk) begin
    x_r[0]   <= xi;
    y_r[0]   <= yi;
    ang_r[0] <= '0;
    spc_r[0] <= SPC_NONE;
    if (xi == '0) begin
      if (yi > 0) begin
        spc_r[0] <= SPC_POS90;
      end else if (yi < 0) begin
        spc_r[0] <= SPC_NEG90;
      end else begin
        spc_r[0] <= SPC_ZERO;
      end
    end else if (xi < 0) begin
      if (yi >= 0) begin
        x_r[0]   <= yi;
        y_r[0]   <= -xi;
        ang_r[0] <= DEG90_Q16;
      end else begin
        x_r[0]   <= -yi;
        y_r[0]   <= xi;
        ang_r[0] <= -DEG90_Q16;
      end
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ANG_W-1:0] ATN = atan_entry(i);
    always_ff @(posedge clk) begin
      spc_r[i+1] <= spc_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1]   <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1]   <= y_r[i] - (x_r[i] >>> i);
        ang_r[i+1] <= ang_r[i] + ATN;
      end else begin
        x_r[i+1]   <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1]   <= y_r[i] + (x_r[i] >>> i);
        ang_r[i+1] <= ang_r[i] - ATN;
      end
    end
  end

  // special cases override the accumulated angle
  always_comb begin
    case (spc_r[STEPS])
      SPC_POS90: ang = DEG90_Q16;
      SPC_NEG90: ang = -DEG90_Q16;
      SPC_ZERO:  ang = '0;
      default:   ang = ang_r[STEPS];
    endcase
  end

endmodule

/* rtl/quaternion_to_euler_degrees_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_top: quaternion to pitch/yaw/roll in degrees
// out_valid follows in_start through the valid shift line and the output register.
// Latency is set by the 29-stage square root and the CORDIC step pipeline.
// One quaternion per cycle; busy is always low; one strobe per transaction.
// Synchronous active-low reset clears the valid pipeline only.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_top import qte_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_quat_x,
  input  logic signed [IN_W-1:0]  in_quat_y,
  input  logic signed [IN_W-1:0]  in_quat_z,
  input  logic signed [IN_W-1:0]  in_quat_w,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_pitch_deg,
  output logic signed [YAW_W-1:0] out_yaw_deg,
  output logic signed [OUT_W-1:0] out_roll_deg,
  output logic                    out_yaw_saturated
);

  localparam int V_LEN   = CORDIC_STEPS + 35;
  localparam int SAT_LEN = CORDIC_STEPS + 32;
  localparam int SC_LEN  = 31;
  localparam int ARG_LEN = 32;

  assign busy = 1'b0;

  // valid shift line
  logic v_r [0:V_LEN-1];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < V_LEN; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_start;
      for (int k = 1; k < V_LEN; k++) v_r[k] <= v_r[k-1];
    end
  end

  // stage A: products
  logic signed [PRD_W-1:0] xx_r, yy_r, zz_r, ww_r, yz_r, wx_r, xy_r, wz_r, wy_r, xz_r;
  always_ff @(posedge clk) begin
    xx_r <= in_quat_x * in_quat_x;
    yy_r <= in_quat_y * in_quat_y;
    zz_r <= in_quat_z * in_quat_z;
    ww_r <= in_quat_w * in_quat_w;
    yz_r <= in_quat_y * in_quat_z;
    wx_r <= in_quat_w * in_quat_x;
    xy_r <= in_quat_x * in_quat_y;
    wz_r <= in_quat_w * in_quat_z;
    wy_r <= in_quat_w * in_quat_y;
    xz_r <= in_quat_x * in_quat_z;
  end

  // stage B: numerators and denominators
  logic signed [ARG_W-1:0] pn_r, pd_r, rn_r, rd_r, s_r;
  always_ff @(posedge clk) begin
    pn_r <= (ARG_W'(yz_r) + ARG_W'(wx_r)) <<< 1;
    pd_r <= ARG_W'(ww_r) - ARG_W'(xx_r) - ARG_W'(yy_r) + ARG_W'(zz_r);
    rn_r <= (ARG_W'(xy_r) + ARG_W'(wz_r)) <<< 1;
    rd_r <= ARG_W'(ww_r) + ARG_W'(xx_r) - ARG_W'(yy_r) - ARG_W'(zz_r);
    s_r  <= (ARG_W'(wy_r) - ARG_W'(xz_r)) <<< 1;
  end

  // stage C: clamp sine to unit range
  logic signed [SC_W-1:0] sc_r;
  logic                   sat_r;
  always_ff @(posedge clk) begin
    if (s_r > ONE_Q28) begin
      sc_r  <= SC_W'(ONE_Q28);
      sat_r <= 1'b1;
    end else if (s_r < -ONE_Q28) begin
      sc_r  <= SC_W'(-ONE_Q28);
      sat_r <= 1'b1;
    end else begin
      sc_r  <= SC_W'(s_r);
      sat_r <= 1'b0;
    end
  end

  // stage D: square; stage E: 1 - s^2
  logic signed [2*SC_W-1:0] sq_r;
  logic [REM_W-1:0]         rem_r;
  always_ff @(posedge clk) begin
    sq_r  <= sc_r * sc_r;
    rem_r <= (REM_W'(1) << ISQ_TOP) - sq_r[REM_W-1:0];
  end

  // square root, one result bit per stage
  logic [ISQ_W-1:0] iv_r  [1:ISQ_N];
  logic [ISQ_W-1:0] ires_r[1:ISQ_N];
  for (genvar k = 0; k < ISQ_N; k++) begin : g_isq
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (ISQ_TOP - 2 * k);
    logic [ISQ_W-1:0] v_in;
    logic [ISQ_W-1:0] r_in;
    logic [ISQ_W-1:0] trial;
    if (k == 0) begin : g_first
      assign v_in = ISQ_W'(rem_r);
      assign r_in = '0;
    end else begin : g_next
      assign v_in = iv_r[k];
      assign r_in = ires_r[k];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (v_in >= trial) begin
        iv_r[k+1]   <= v_in - trial;
        ires_r[k+1] <= (r_in >> 1) + BIT;
      end else begin
        iv_r[k+1]   <= v_in;
        ires_r[k+1] <= r_in >> 1;
      end
    end
  end

  // alignment lines for the sine, the flag and the pitch/roll arguments
  logic signed [SC_W-1:0]  scd_r [0:SC_LEN-1];
  logic                    satd_r[0:SAT_LEN-1];
  logic signed [ARG_W-1:0] pnd_r [0:ARG_LEN-1];
  logic signed [ARG_W-1:0] pdd_r [0:ARG_LEN-1];
  logic signed [ARG_W-1:0] rnd_r [0:ARG_LEN-1];
  logic signed [ARG_W-1:0] rdd_r [0:ARG_LEN-1];
  always_ff @(posedge clk) begin
    scd_r[0]  <= sc_r;
    satd_r[0] <= sat_r;
    pnd_r[0]  <= pn_r;
    pdd_r[0]  <= pd_r;
    rnd_r[0]  <= rn_r;
    rdd_r[0]  <= rd_r;
    for (int k = 1; k < SC_LEN; k++) scd_r[k] <= scd_r[k-1];
    for (int k = 1; k < SAT_LEN; k++) satd_r[k] <= satd_r[k-1];
    for (int k = 1; k < ARG_LEN; k++) begin
      pnd_r[k] <= pnd_r[k-1];
      pdd_r[k] <= pdd_r[k-1];
      rnd_r[k] <= rnd_r[k-1];
      rdd_r[k] <= rdd_r[k-1];
    end
  end

  // three atan2 pipelines
  logic signed [ARG_W-1:0] yaw_y, yaw_x;
  logic signed [ANG_W-1:0] pitch_ang, yaw_ang, roll_ang;
  assign yaw_y = ARG_W'(scd_r[SC_LEN-1]);
  assign yaw_x = ARG_W'({1'b0, ires_r[ISQ_N][ISQ_N-1:0]});

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .arg_y(pnd_r[ARG_LEN-1]), .arg_x(pdd_r[ARG_LEN-1]), .ang(pitch_ang)
  );
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .arg_y(rnd_r[ARG_LEN-1]), .arg_x(rdd_r[ARG_LEN-1]), .ang(roll_ang)
  );
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .arg_y(yaw_y), .arg_x(yaw_x), .ang(yaw_ang)
  );

  // output register: rounding, clamping, saturated yaw
  logic                    sat_end;
  logic signed [OUT_W-1:0] yaw_full;
  assign sat_end  = satd_r[SAT_LEN-1];
  assign yaw_full = round_clamp(yaw_ang, YAW_LIM);

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pitch_r, roll_r;
  logic signed [YAW_W-1:0] yaw_r;
  logic                    ysat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[V_LEN-1];
    end
    pitch_r <= round_clamp(pitch_ang, PITCH_LIM);
    roll_r  <= round_clamp(roll_ang, PITCH_LIM);
    ysat_r  <= sat_end;
    // a clamped sine leaves a zero cosine, so the CORDIC gives exactly +-90
    yaw_r   <= yaw_full[YAW_W-1:0];
  end

  assign out_valid         = out_valid_r;
  assign out_pitch_deg     = pitch_r;
  assign out_yaw_deg       = yaw_r;
  assign out_roll_deg      = roll_r;
  assign out_yaw_saturated = ysat_r;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for quaternion_to_euler_degrees_top
// Drives quaternions through the command port with random gaps, works out
// pitch, yaw and roll with a local fixed-point CORDIC model and checks every
// result strobe in order against the queue of predicted angles.
// ----------------------------------------------------------------------------
module tb_top;
  import qte_pkg::*;

  localparam int STEPS     = 16;
  localparam int LATENCY   = STEPS + 36;
  localparam int MAX_CYC   = 400000;

  typedef struct packed {
    logic signed [OUT_W-1:0] pitch;
    logic signed [YAW_W-1:0] yaw;
    logic signed [OUT_W-1:0] roll;
    logic                    sat;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] in_quat_x = '0;
  logic signed [IN_W-1:0] in_quat_y = '0;
  logic signed [IN_W-1:0] in_quat_z = '0;
  logic signed [IN_W-1:0] in_quat_w = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_pitch_deg;
  logic signed [YAW_W-1:0] out_yaw_deg;
  logic signed [OUT_W-1:0] out_roll_deg;
  logic out_yaw_saturated;

  angles_t angles_q[$];
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_errors = 0;
  int cyc = 0;

  quaternion_to_euler_degrees_top #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #5 clk = ~clk;

  // atan(2^-i), degrees * 65536
  function automatic longint atan_step(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  function automatic longint deg_atan2(longint yv, longint xv);
    longint a, t, xs, ys;
    a = 0;
    if (xv == 0) return (yv > 0) ? 90*65536 : (yv < 0) ? -90*65536 : 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t; a = 90*65536;
      end else begin
        t = xv; xv = -yv; yv = t; a = -90*65536;
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv = xv + ys; yv = yv - xs; a += atan_step(i);
      end else begin
        xv = xv - ys; yv = yv + xs; a -= atan_step(i);
      end
    end
    return a;
  endfunction

  function automatic longint to_units(longint a, longint lim);
    longint r;
    r = (a + 256) >>> 9;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // floor square root, bit by bit
  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                       logic signed [15:0] qz, logic signed [15:0] qw);
    longint x, y, z, w, s, c;
    angles_t r;
    x = qx; y = qy; z = qz; w = qw;
    r.pitch = to_units(deg_atan2(2*(y*z + w*x), w*w - x*x - y*y + z*z), 23040);
    r.roll  = to_units(deg_atan2(2*(x*y + w*z), w*w + x*x - y*y - z*z), 23040);
    s = 2*(w*y - x*z);
    r.sat = 1'b0;
    if (s > (64'sd1 << 28)) begin s = 64'sd1 << 28; r.sat = 1'b1; end
    if (s < -(64'sd1 << 28)) begin s = -(64'sd1 << 28); r.sat = 1'b1; end
    if (r.sat) begin
      r.yaw = (s > 0) ? 15'sd11520 : -15'sd11520;
    end else begin
      c = floor_sqrt((64'd1 << 56) - longint'(s*s));
      r.yaw = to_units(deg_atan2(s, c), 11520);
    end
    return r;
  endfunction

  // send one transaction, after a random gap when gaps is set
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_start  <= 1'b1;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    @(posedge clk);
    while (busy) @(posedge clk);
    angles_q = {angles_q, euler_of(qx, qy, qz, qw)};
    n_sent++;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'(-16384 + 32768 * $urandom_range(0, 1));
      1: return 16'($urandom);
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // extremes, axes, zero arguments and saturating yaw
  task automatic test_directed();
    send_quat(0, 0, 0, 0, 0);
    send_quat(0, 0, 0, 16384, 0);
    send_quat(0, 0, 0, -16384, 1);
    send_quat(16384, 0, 0, 0, 0);
    send_quat(0, 16384, 0, 0, 0);
    send_quat(0, 0, 16384, 0, 1);
    send_quat(11585, 0, 0, 11585, 0);
    send_quat(0, 11585, 0, 11585, 0);
    send_quat(0, -11585, 0, 11585, 0);
    send_quat(0, 0, 11585, 11585, 0);
    send_quat(16384, 16384, 16384, 16384, 1);
    send_quat(-16384, -16384, -16384, -16384, 0);
    send_quat(-16384, 16384, 16384, 16384, 0);
    send_quat(16384, -16384, 16384, -16384, 0);
    send_quat(-32768, -32768, -32768, -32768, 0);
    send_quat(32767, 32767, 32767, 32767, 0);
    send_quat(32767, -32768, 32767, -32768, 1);
    send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
    send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0);
    send_quat(1, 0, 0, -1, 0);
    send_quat(0, 8192, 0, 8192, 0);
  endtask

  // mostly unit-ish quaternions with random content, some raw noise
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 2) != 0);
      else
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  (i / 50) % 3 != 0);
    end
    in_start <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    angles_t exp_a;
    cyc <= cyc + 1;
    if (rst_n && out_valid) begin
      if (angles_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction at cycle %0d", cyc);
      end else begin
        exp_a = angles_q.pop_front();
        n_checked++;
        if (out_yaw_saturated) n_sat++;
        if (out_pitch_deg !== exp_a.pitch || out_yaw_deg !== exp_a.yaw ||
            out_roll_deg !== exp_a.roll || out_yaw_saturated !== exp_a.sat) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: exp p=%0d y=%0d r=%0d s=%0b got p=%0d y=%0d r=%0d s=%0b",
                     n_checked, exp_a.pitch, exp_a.yaw, exp_a.roll, exp_a.sat,
                     out_pitch_deg, out_yaw_deg, out_roll_deg, out_yaw_saturated);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cyc > MAX_CYC) begin
      $display("timeout at cycle %0d", cyc);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    while (angles_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (angles_q.size() != 0) n_errors++;
    $display("sent %0d quaternions, checked %0d results (%0d with yaw clamped)",
             n_sent, n_checked, n_sat);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
